>>> src/jtl_pkg.sv
// Shared types, constants and character helpers for the template lexer.
package jtl_pkg;

  localparam int SPACE_DEPTH = 32;
  localparam int IDX_W = $clog2(SPACE_DEPTH);
  localparam int CNT_W = $clog2(SPACE_DEPTH + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [4:0] TK_TEXT       = 5'd0;
  localparam logic [4:0] TK_EXPR_OPEN  = 5'd1;
  localparam logic [4:0] TK_EXPR_CLOSE = 5'd2;
  localparam logic [4:0] TK_STMT_OPEN  = 5'd3;
  localparam logic [4:0] TK_STMT_CLOSE = 5'd4;
  localparam logic [4:0] TK_STRING     = 5'd5;
  localparam logic [4:0] TK_INT        = 5'd6;
  localparam logic [4:0] TK_FLOAT      = 5'd7;
  localparam logic [4:0] TK_IDENT      = 5'd8;
  localparam logic [4:0] TK_DOT        = 5'd9;
  localparam logic [4:0] TK_COMMA      = 5'd10;
  localparam logic [4:0] TK_PIPE       = 5'd11;
  localparam logic [4:0] TK_LPAREN     = 5'd12;
  localparam logic [4:0] TK_RPAREN     = 5'd13;
  localparam logic [4:0] TK_LBRACK     = 5'd14;
  localparam logic [4:0] TK_RBRACK     = 5'd15;
  localparam logic [4:0] TK_PLUS       = 5'd16;
  localparam logic [4:0] TK_MINUS      = 5'd17;
  localparam logic [4:0] TK_STAR       = 5'd18;
  localparam logic [4:0] TK_SLASH      = 5'd19;
  localparam logic [4:0] TK_MOD        = 5'd20;
  localparam logic [4:0] TK_TILDE      = 5'd21;
  localparam logic [4:0] TK_COLON      = 5'd22;
  localparam logic [4:0] TK_EQ         = 5'd23;
  localparam logic [4:0] TK_NE         = 5'd24;
  localparam logic [4:0] TK_LE         = 5'd25;
  localparam logic [4:0] TK_GE         = 5'd26;
  localparam logic [4:0] TK_LT         = 5'd27;
  localparam logic [4:0] TK_GT         = 5'd28;
  localparam logic [4:0] TK_ASSIGN     = 5'd29;
  localparam logic [4:0] TK_EOF        = 5'd30;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_OPEN_STR = 3'd2;
  localparam logic [2:0] ERR_OPEN_CMT = 3'd3;
  localparam logic [2:0] ERR_OPEN_TAG = 3'd4;
  localparam logic [2:0] ERR_OVERFLOW = 3'd5;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [4:0] {
    M_TEXT, M_TEXT_LB, M_OPEN, M_CMT, M_CMT_HASH, M_INNER, M_DASH1, M_DASH2,
    M_END1, M_OP, M_STR, M_ESC, M_NUM, M_ID, M_RT_SP, M_RT_CR, M_ERR
  } scan_mode_e;

  typedef enum logic [3:0] {
    P_IDLE, P_FEED, P_TCHAR, P_TADD, P_CRD, P_CADD, P_TCL, P_CLOSE,
    P_EOF, P_OPENTOK, P_ESC2, P_RST
  } phase_e;

  typedef enum logic [1:0] {
    C_TADD, C_TCHAR, C_CLOSE
  } cont_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_FIXED, DP_ADD, DP_ADD_RD, DP_CLOSE, DP_FAIL, DP_PUSH, DP_CRD,
    DP_CLR_PEND, DP_CUT, DP_UNCUT, DP_STR_START, DP_RESET
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [4:0] kind;
    logic [7:0] ch;
    logic [2:0] code;
    logic       flag;
  } dp_cmd_t;

  typedef struct packed {
    logic pend_zero;
    logic pend_full;
    logic commit_last;
    logic cut;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } fixed_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic fixed_t fixed_kind(logic [7:0] c);
    fixed_t r;
    r.hit = 1'b1;
    case (c)
      8'h2E:   r.kind = TK_DOT;
      8'h2C:   r.kind = TK_COMMA;
      8'h7C:   r.kind = TK_PIPE;
      8'h28:   r.kind = TK_LPAREN;
      8'h29:   r.kind = TK_RPAREN;
      8'h5B:   r.kind = TK_LBRACK;
      8'h5D:   r.kind = TK_RBRACK;
      8'h2B:   r.kind = TK_PLUS;
      8'h2A:   r.kind = TK_STAR;
      8'h2F:   r.kind = TK_SLASH;
      8'h25:   r.kind = TK_MOD;
      8'h7E:   r.kind = TK_TILDE;
      8'h3A:   r.kind = TK_COLON;
      default: begin
        r.hit  = 1'b0;
        r.kind = TK_TEXT;
      end
    endcase
    return r;
  endfunction

endpackage

>>> src/jinja_template_lexer_top.sv
// Top level of the template lexer: stream ports, controller and datapath.
//
//   Channel  Dir  Signals                     Payload
//   s_axis   in   tvalid/tready/tdata/tuser   template byte, end-of-template flag
//   m_axis   out  tvalid/tready/tdata/tlast   token result, last result of token
//
// A tag byte is accepted and then given a scan step; a text byte is accepted, given a scan
// step and then a hold or append step. A byte that closes a token is scanned again.
// Opening a tag runs these scan steps in order: flush or trim, close text, open token, re-scan.
// Flushing held whitespace reads each held byte from the store, then emits it.
// End of template is followed by a reset step that clears the lexer state.
// Reset clears all control state; the whitespace store is not cleared.
// Every scan step waits while the output register holds an unaccepted result.
module jinja_template_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [4:0] token_kind, [12:5] token_char,
                                        // [13] has_char, [14] token_first,
                                        // [17:15] error_code, [23:18] zero
  output logic        m_axis_tlast_o    // token_last
);

  jtl_pkg::dp_cmd_t  cmd;
  jtl_pkg::dp_stat_t stat;
  logic [4:0] res_kind;
  logic [7:0] res_char;
  logic       res_has;
  logic       res_first;
  logic       res_last;
  logic [2:0] res_err;

  jtl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_eof_i   (s_axis_tuser_i),
    .in_byte_i  (s_axis_tdata_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  jtl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_kind_o  (res_kind),
    .out_char_o  (res_char),
    .out_has_o   (res_has),
    .out_first_o (res_first),
    .out_last_o  (res_last),
    .out_err_o   (res_err)
  );

  assign m_axis_tdata_o = {6'b000000, res_err, res_first, res_has, res_char, res_kind};
  assign m_axis_tlast_o = res_last;

endmodule

>>> src/jtl_dp.sv
// Lexer datapath: whitespace store, delayed character, result register.
module jtl_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jtl_pkg::dp_cmd_t  cmd_i,
  output jtl_pkg::dp_stat_t stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [4:0]        out_kind_o,
  output logic [7:0]        out_char_o,
  output logic              out_has_o,
  output logic              out_first_o,
  output logic              out_last_o,
  output logic [2:0]        out_err_o
);

  logic [7:0] space_mem [jtl_pkg::SPACE_DEPTH];

  jtl_pkg::cnt_t cnt_q, cnt_d;
  jtl_pkg::idx_t cidx_q, cidx_d;
  logic          dv_q, dv_d;
  logic          ts_q, ts_d;
  logic          cut_q, cut_d;
  logic [7:0]    dchar_q, dchar_d;
  logic [7:0]    rdata_q;
  logic          out_valid_q, out_valid_d;
  logic [4:0]    kind_q;
  logic [7:0]    char_q;
  logic          has_q, first_q, last_q;
  logic [2:0]    err_q;

  logic          emit;
  logic [4:0]    r_kind;
  logic [7:0]    r_char;
  logic          r_has, r_first, r_last;
  logic [2:0]    r_err;
  logic          last_rd;

  assign last_rd = (jtl_pkg::cnt_t'(cidx_q) + jtl_pkg::cnt_t'(1)) == cnt_q;

  assign stat_o.pend_zero   = (cnt_q == '0);
  assign stat_o.pend_full   = (cnt_q == jtl_pkg::cnt_t'(jtl_pkg::SPACE_DEPTH));
  assign stat_o.commit_last = last_rd;
  assign stat_o.cut         = cut_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    emit    = 1'b0;
    r_kind  = cmd_i.kind;
    r_char  = 8'h00;
    r_has   = 1'b0;
    r_first = 1'b1;
    r_last  = 1'b1;
    r_err   = jtl_pkg::ERR_NONE;
    cnt_d   = cnt_q;
    cidx_d  = cidx_q;
    dv_d    = dv_q;
    ts_d    = ts_q;
    cut_d   = cut_q;
    dchar_d = dchar_q;
    unique case (cmd_i.op)
      jtl_pkg::DP_FIXED: begin
        emit = 1'b1;
      end
      jtl_pkg::DP_ADD, jtl_pkg::DP_ADD_RD: begin
        emit    = dv_q;
        r_char  = dchar_q;
        r_has   = 1'b1;
        r_first = !ts_q;
        r_last  = 1'b0;
        if (dv_q) begin
          ts_d = 1'b1;
        end
        dv_d = 1'b1;
        if (cmd_i.op == jtl_pkg::DP_ADD_RD) begin
          dchar_d = rdata_q;
          if (last_rd) begin
            cnt_d  = '0;
            cidx_d = '0;
          end else begin
            cidx_d = cidx_q + jtl_pkg::idx_t'(1);
          end
        end else begin
          dchar_d = cmd_i.ch;
        end
      end
      jtl_pkg::DP_CLOSE: begin
        if (dv_q) begin
          emit    = 1'b1;
          r_char  = dchar_q;
          r_has   = 1'b1;
          r_first = !ts_q;
        end else begin
          emit = cmd_i.flag && !ts_q;
        end
        dv_d  = 1'b0;
        ts_d  = 1'b0;
        cut_d = 1'b0;
      end
      jtl_pkg::DP_FAIL: begin
        emit   = 1'b1;
        r_kind = jtl_pkg::TK_TEXT;
        r_err  = cmd_i.code;
      end
      jtl_pkg::DP_PUSH: begin
        cnt_d = cnt_q + jtl_pkg::cnt_t'(1);
      end
      jtl_pkg::DP_CLR_PEND: begin
        cnt_d = '0;
      end
      jtl_pkg::DP_CUT: begin
        cut_d = 1'b1;
      end
      jtl_pkg::DP_UNCUT: begin
        cut_d = 1'b0;
      end
      jtl_pkg::DP_STR_START: begin
        dv_d = 1'b0;
        ts_d = 1'b0;
      end
      jtl_pkg::DP_RESET: begin
        cnt_d  = '0;
        cidx_d = '0;
        dv_d   = 1'b0;
        ts_d   = 1'b0;
        cut_d  = 1'b0;
      end
      jtl_pkg::DP_NOP, jtl_pkg::DP_CRD: begin
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == jtl_pkg::DP_PUSH) begin
      space_mem[cnt_q[jtl_pkg::IDX_W-1:0]] <= cmd_i.ch;
    end
    if (cmd_i.op == jtl_pkg::DP_CRD) begin
      rdata_q <= space_mem[cidx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cidx_q      <= '0;
      dv_q        <= 1'b0;
      ts_q        <= 1'b0;
      cut_q       <= 1'b0;
      dchar_q     <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      cidx_q      <= cidx_d;
      dv_q        <= dv_d;
      ts_q        <= ts_d;
      cut_q       <= cut_d;
      dchar_q     <= dchar_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q  <= r_kind;
      char_q  <= r_char;
      has_q   <= r_has;
      first_q <= r_first;
      last_q  <= r_last;
      err_q   <= r_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_char_o  = char_q;
  assign out_has_o   = has_q;
  assign out_first_o = first_q;
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

endmodule

>>> src/jtl_ctrl.sv
// Lexer controller: scan mode, step sequencing and datapath commands.
module jtl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_eof_i,
  input  logic [7:0]        in_byte_i,
  input  jtl_pkg::dp_stat_t stat_i,
  output jtl_pkg::dp_cmd_t  cmd_o
);

  jtl_pkg::phase_e     phase_q, phase_d;
  jtl_pkg::scan_mode_e mode_q, mode_d;
  jtl_pkg::cont_e      cont_q, cont_d;
  logic [7:0] sym_q, sym_d;
  logic       sym_eof_q, sym_eof_d;
  logic       item_eof_q, item_eof_d;
  logic [7:0] sec_q, sec_d;
  logic       sec_eof_q, sec_eof_d;
  logic       sec_valid_q, sec_valid_d;
  logic [7:0] held_q, held_d;
  logic [7:0] tc_q, tc_d;
  logic       stmt_q, stmt_d;
  logic       qd_q, qd_d;
  logic       dot_q, dot_d;
  logic       trim_q, trim_d;
  logic       after_feed_q, after_feed_d;
  logic       close_open_q, close_open_d;

  logic             finish;
  logic             failed;
  logic [7:0]       b;
  logic             e;
  logic [7:0]       end0;
  jtl_pkg::fixed_t  fx;
  logic [4:0]       close_kind;
  logic [4:0]       open_kind;

  assign b          = sym_q;
  assign e          = sym_eof_q;
  assign end0       = stmt_q ? jtl_pkg::CH_PCT : jtl_pkg::CH_RBRACE;
  assign fx         = jtl_pkg::fixed_kind(sym_q);
  assign close_kind = stmt_q ? jtl_pkg::TK_STMT_CLOSE : jtl_pkg::TK_EXPR_CLOSE;
  assign open_kind  = stmt_q ? jtl_pkg::TK_STMT_OPEN : jtl_pkg::TK_EXPR_OPEN;

  always_comb begin
    phase_d      = phase_q;
    mode_d       = mode_q;
    cont_d       = cont_q;
    sym_d        = sym_q;
    sym_eof_d    = sym_eof_q;
    item_eof_d   = item_eof_q;
    sec_d        = sec_q;
    sec_eof_d    = sec_eof_q;
    sec_valid_d  = sec_valid_q;
    held_d       = held_q;
    tc_d         = tc_q;
    stmt_d       = stmt_q;
    qd_d         = qd_q;
    dot_d        = dot_q;
    trim_d       = trim_q;
    after_feed_d = after_feed_q;
    close_open_d = close_open_q;
    cmd_o        = '{op: jtl_pkg::DP_NOP, default: '0};
    in_ready_o   = 1'b0;
    finish       = 1'b0;
    failed       = 1'b0;

    if (phase_q == jtl_pkg::P_IDLE) begin
      in_ready_o = 1'b1;
      if (in_valid_i) begin
        sym_d      = in_byte_i;
        sym_eof_d  = in_eof_i;
        item_eof_d = in_eof_i;
        phase_d    = jtl_pkg::P_FEED;
      end
    end else if (stat_i.out_free) begin
      unique case (phase_q)
        jtl_pkg::P_FEED: begin
          unique case (mode_q)
            jtl_pkg::M_TEXT: begin
              if (e) begin
                trim_d       = 1'b0;
                close_open_d = 1'b0;
                phase_d      = jtl_pkg::P_TCL;
              end else if (b == jtl_pkg::CH_LBRACE) begin
                mode_d = jtl_pkg::M_TEXT_LB;
                finish = 1'b1;
              end else begin
                tc_d         = b;
                after_feed_d = 1'b0;
                phase_d      = jtl_pkg::P_TCHAR;
              end
            end
            jtl_pkg::M_TEXT_LB: begin
              if (!e && (b == jtl_pkg::CH_LBRACE || b == jtl_pkg::CH_PCT)) begin
                stmt_d = (b == jtl_pkg::CH_PCT);
                mode_d = jtl_pkg::M_OPEN;
                finish = 1'b1;
              end else if (!e && b == jtl_pkg::CH_HASH) begin
                mode_d = jtl_pkg::M_CMT;
                finish = 1'b1;
              end else begin
                mode_d       = jtl_pkg::M_TEXT;
                tc_d         = jtl_pkg::CH_LBRACE;
                after_feed_d = 1'b1;
                phase_d      = jtl_pkg::P_TCHAR;
              end
            end
            jtl_pkg::M_OPEN: begin
              trim_d       = !e && (b == jtl_pkg::CH_MINUS);
              close_open_d = 1'b1;
              phase_d      = jtl_pkg::P_TCL;
            end
            jtl_pkg::M_CMT: begin
              if (e) begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_OPEN_CMT;
                failed     = 1'b1;
              end else begin
                if (b == jtl_pkg::CH_HASH) begin
                  mode_d = jtl_pkg::M_CMT_HASH;
                end
                finish = 1'b1;
              end
            end
            jtl_pkg::M_CMT_HASH: begin
              if (e) begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_OPEN_CMT;
                failed     = 1'b1;
              end else begin
                if (b == jtl_pkg::CH_RBRACE) begin
                  mode_d   = jtl_pkg::M_TEXT;
                  cmd_o.op = jtl_pkg::DP_CUT;
                end else if (b != jtl_pkg::CH_HASH) begin
                  mode_d = jtl_pkg::M_CMT;
                end
                finish = 1'b1;
              end
            end
            jtl_pkg::M_INNER: begin
              priority if (e) begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_OPEN_TAG;
                failed     = 1'b1;
              end else if (jtl_pkg::is_ws(b)) begin
                finish = 1'b1;
              end else if (b == jtl_pkg::CH_MINUS) begin
                mode_d = jtl_pkg::M_DASH1;
                finish = 1'b1;
              end else if (b == end0) begin
                mode_d = jtl_pkg::M_END1;
                finish = 1'b1;
              end else if (b == jtl_pkg::CH_DQUOTE || b == jtl_pkg::CH_SQUOTE) begin
                qd_d     = (b == jtl_pkg::CH_DQUOTE);
                cmd_o.op = jtl_pkg::DP_STR_START;
                mode_d   = jtl_pkg::M_STR;
                finish   = 1'b1;
              end else if (jtl_pkg::is_digit(b)) begin
                dot_d      = 1'b0;
                mode_d     = jtl_pkg::M_NUM;
                cmd_o.op   = jtl_pkg::DP_ADD;
                cmd_o.kind = jtl_pkg::TK_INT;
                cmd_o.ch   = b;
                finish     = 1'b1;
              end else if (jtl_pkg::is_alpha(b) || b == jtl_pkg::CH_UNDER) begin
                mode_d     = jtl_pkg::M_ID;
                cmd_o.op   = jtl_pkg::DP_ADD;
                cmd_o.kind = jtl_pkg::TK_IDENT;
                cmd_o.ch   = b;
                finish     = 1'b1;
              end else if (fx.hit) begin
                cmd_o.op   = jtl_pkg::DP_FIXED;
                cmd_o.kind = fx.kind;
                finish     = 1'b1;
              end else if (b == jtl_pkg::CH_EQ || b == jtl_pkg::CH_BANG ||
                           b == jtl_pkg::CH_LT || b == jtl_pkg::CH_GT) begin
                held_d = b;
                mode_d = jtl_pkg::M_OP;
                finish = 1'b1;
              end else begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_BAD_CHAR;
                failed     = 1'b1;
              end
            end
            jtl_pkg::M_DASH1: begin
              if (!e && b == end0) begin
                mode_d = jtl_pkg::M_DASH2;
                finish = 1'b1;
              end else begin
                mode_d     = jtl_pkg::M_INNER;
                cmd_o.op   = jtl_pkg::DP_FIXED;
                cmd_o.kind = jtl_pkg::TK_MINUS;
              end
            end
            jtl_pkg::M_DASH2: begin
              if (!e && b == jtl_pkg::CH_RBRACE) begin
                cmd_o.op   = jtl_pkg::DP_FIXED;
                cmd_o.kind = close_kind;
                mode_d     = jtl_pkg::M_RT_SP;
                finish     = 1'b1;
              end else begin
                mode_d      = jtl_pkg::M_INNER;
                cmd_o.op    = jtl_pkg::DP_FIXED;
                cmd_o.kind  = jtl_pkg::TK_MINUS;
                sec_d       = b;
                sec_eof_d   = e;
                sec_valid_d = 1'b1;
                sym_d       = end0;
                sym_eof_d   = 1'b0;
              end
            end
            jtl_pkg::M_END1: begin
              if (!e && b == jtl_pkg::CH_RBRACE) begin
                cmd_o.op   = jtl_pkg::DP_FIXED;
                cmd_o.kind = close_kind;
                mode_d     = jtl_pkg::M_TEXT;
                finish     = 1'b1;
              end else if (!stmt_q) begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_BAD_CHAR;
                failed     = 1'b1;
              end else begin
                mode_d     = jtl_pkg::M_INNER;
                cmd_o.op   = jtl_pkg::DP_FIXED;
                cmd_o.kind = jtl_pkg::TK_MOD;
              end
            end
            jtl_pkg::M_OP: begin
              if (!e && b == jtl_pkg::CH_EQ) begin
                mode_d   = jtl_pkg::M_INNER;
                cmd_o.op = jtl_pkg::DP_FIXED;
                priority if (held_q == jtl_pkg::CH_EQ) cmd_o.kind = jtl_pkg::TK_EQ;
                else if (held_q == jtl_pkg::CH_BANG) cmd_o.kind = jtl_pkg::TK_NE;
                else if (held_q == jtl_pkg::CH_LT) cmd_o.kind = jtl_pkg::TK_LE;
                else cmd_o.kind = jtl_pkg::TK_GE;
                finish = 1'b1;
              end else if (held_q == jtl_pkg::CH_BANG) begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_BAD_CHAR;
                failed     = 1'b1;
              end else begin
                mode_d   = jtl_pkg::M_INNER;
                cmd_o.op = jtl_pkg::DP_FIXED;
                priority if (held_q == jtl_pkg::CH_EQ) cmd_o.kind = jtl_pkg::TK_ASSIGN;
                else if (held_q == jtl_pkg::CH_LT) cmd_o.kind = jtl_pkg::TK_LT;
                else cmd_o.kind = jtl_pkg::TK_GT;
              end
            end
            jtl_pkg::M_STR: begin
              priority if (e) begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_OPEN_STR;
                failed     = 1'b1;
              end else if (b == (qd_q ? jtl_pkg::CH_DQUOTE : jtl_pkg::CH_SQUOTE)) begin
                cmd_o.op   = jtl_pkg::DP_CLOSE;
                cmd_o.kind = jtl_pkg::TK_STRING;
                cmd_o.flag = 1'b1;
                mode_d     = jtl_pkg::M_INNER;
                finish     = 1'b1;
              end else if (b == jtl_pkg::CH_BSLASH) begin
                mode_d = jtl_pkg::M_ESC;
                finish = 1'b1;
              end else begin
                cmd_o.op   = jtl_pkg::DP_ADD;
                cmd_o.kind = jtl_pkg::TK_STRING;
                cmd_o.ch   = b;
                finish     = 1'b1;
              end
            end
            jtl_pkg::M_ESC: begin
              if (e) begin
                cmd_o.op   = jtl_pkg::DP_FAIL;
                cmd_o.code = jtl_pkg::ERR_OPEN_STR;
                failed     = 1'b1;
              end else begin
                mode_d     = jtl_pkg::M_STR;
                cmd_o.op   = jtl_pkg::DP_ADD;
                cmd_o.kind = jtl_pkg::TK_STRING;
                finish     = 1'b1;
                priority if (b == jtl_pkg::CH_N) cmd_o.ch = jtl_pkg::CH_LF;
                else if (b == jtl_pkg::CH_T) cmd_o.ch = jtl_pkg::CH_TAB;
                else if (b == jtl_pkg::CH_R) cmd_o.ch = jtl_pkg::CH_CR;
                else if (b == jtl_pkg::CH_BSLASH || b == jtl_pkg::CH_SQUOTE ||
                         b == jtl_pkg::CH_DQUOTE) cmd_o.ch = b;
                else begin
                  cmd_o.ch = jtl_pkg::CH_BSLASH;
                  finish   = 1'b0;
                  phase_d  = jtl_pkg::P_ESC2;
                end
              end
            end
            jtl_pkg::M_NUM: begin
              if (!e && jtl_pkg::is_digit(b)) begin
                cmd_o.op   = jtl_pkg::DP_ADD;
                cmd_o.kind = dot_q ? jtl_pkg::TK_FLOAT : jtl_pkg::TK_INT;
                cmd_o.ch   = b;
                finish     = 1'b1;
              end else if (!e && b == jtl_pkg::CH_DOT && !dot_q) begin
                dot_d      = 1'b1;
                cmd_o.op   = jtl_pkg::DP_ADD;
                cmd_o.kind = jtl_pkg::TK_FLOAT;
                cmd_o.ch   = b;
                finish     = 1'b1;
              end else begin
                cmd_o.op   = jtl_pkg::DP_CLOSE;
                cmd_o.kind = dot_q ? jtl_pkg::TK_FLOAT : jtl_pkg::TK_INT;
                mode_d     = jtl_pkg::M_INNER;
              end
            end
            jtl_pkg::M_ID: begin
              if (!e && (jtl_pkg::is_alpha(b) || jtl_pkg::is_digit(b) ||
                         b == jtl_pkg::CH_UNDER)) begin
                cmd_o.op   = jtl_pkg::DP_ADD;
                cmd_o.kind = jtl_pkg::TK_IDENT;
                cmd_o.ch   = b;
                finish     = 1'b1;
              end else begin
                cmd_o.op   = jtl_pkg::DP_CLOSE;
                cmd_o.kind = jtl_pkg::TK_IDENT;
                mode_d     = jtl_pkg::M_INNER;
              end
            end
            jtl_pkg::M_RT_SP: begin
              priority if (!e && (b == jtl_pkg::CH_SPACE || b == jtl_pkg::CH_TAB)) begin
                finish = 1'b1;
              end else if (!e && b == jtl_pkg::CH_LF) begin
                mode_d = jtl_pkg::M_TEXT;
                finish = 1'b1;
              end else if (!e && b == jtl_pkg::CH_CR) begin
                mode_d = jtl_pkg::M_RT_CR;
                finish = 1'b1;
              end else begin
                mode_d = jtl_pkg::M_TEXT;
              end
            end
            jtl_pkg::M_RT_CR: begin
              mode_d = jtl_pkg::M_TEXT;
              if (!e && b == jtl_pkg::CH_LF) begin
                finish = 1'b1;
              end
            end
            jtl_pkg::M_ERR: begin
              finish = 1'b1;
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
        jtl_pkg::P_TCHAR: begin
          priority if (stat_i.cut) begin
            cmd_o.op = jtl_pkg::DP_UNCUT;
            if (!stat_i.pend_zero) begin
              cont_d  = jtl_pkg::C_TCHAR;
              phase_d = jtl_pkg::P_CRD;
            end
          end else if (jtl_pkg::is_ws(tc_q)) begin
            if (stat_i.pend_full) begin
              cmd_o.op   = jtl_pkg::DP_FAIL;
              cmd_o.code = jtl_pkg::ERR_OVERFLOW;
              failed     = 1'b1;
            end else begin
              cmd_o.op = jtl_pkg::DP_PUSH;
              cmd_o.ch = tc_q;
              if (after_feed_q) begin
                phase_d = jtl_pkg::P_FEED;
              end else begin
                finish = 1'b1;
              end
            end
          end else if (!stat_i.pend_zero) begin
            cont_d  = jtl_pkg::C_TADD;
            phase_d = jtl_pkg::P_CRD;
          end else begin
            cmd_o.op   = jtl_pkg::DP_ADD;
            cmd_o.kind = jtl_pkg::TK_TEXT;
            cmd_o.ch   = tc_q;
            if (after_feed_q) begin
              phase_d = jtl_pkg::P_FEED;
            end else begin
              finish = 1'b1;
            end
          end
        end
        jtl_pkg::P_TADD: begin
          cmd_o.op   = jtl_pkg::DP_ADD;
          cmd_o.kind = jtl_pkg::TK_TEXT;
          cmd_o.ch   = tc_q;
          if (after_feed_q) begin
            phase_d = jtl_pkg::P_FEED;
          end else begin
            finish = 1'b1;
          end
        end
        jtl_pkg::P_CRD: begin
          cmd_o.op = jtl_pkg::DP_CRD;
          phase_d  = jtl_pkg::P_CADD;
        end
        jtl_pkg::P_CADD: begin
          cmd_o.op   = jtl_pkg::DP_ADD_RD;
          cmd_o.kind = jtl_pkg::TK_TEXT;
          if (stat_i.commit_last) begin
            unique case (cont_q)
              jtl_pkg::C_TADD:  phase_d = jtl_pkg::P_TADD;
              jtl_pkg::C_TCHAR: phase_d = jtl_pkg::P_TCHAR;
              jtl_pkg::C_CLOSE: phase_d = jtl_pkg::P_CLOSE;
              default:          phase_d = jtl_pkg::P_CLOSE;
            endcase
          end else begin
            phase_d = jtl_pkg::P_CRD;
          end
        end
        jtl_pkg::P_TCL: begin
          priority if (trim_q) begin
            cmd_o.op = jtl_pkg::DP_CLR_PEND;
            phase_d  = jtl_pkg::P_CLOSE;
          end else if (!stat_i.pend_zero) begin
            cont_d  = jtl_pkg::C_CLOSE;
            phase_d = jtl_pkg::P_CRD;
          end else begin
            phase_d = jtl_pkg::P_CLOSE;
          end
        end
        jtl_pkg::P_CLOSE: begin
          cmd_o.op   = jtl_pkg::DP_CLOSE;
          cmd_o.kind = jtl_pkg::TK_TEXT;
          phase_d    = close_open_q ? jtl_pkg::P_OPENTOK : jtl_pkg::P_EOF;
        end
        jtl_pkg::P_EOF: begin
          cmd_o.op   = jtl_pkg::DP_FIXED;
          cmd_o.kind = jtl_pkg::TK_EOF;
          finish     = 1'b1;
        end
        jtl_pkg::P_OPENTOK: begin
          cmd_o.op   = jtl_pkg::DP_FIXED;
          cmd_o.kind = open_kind;
          mode_d     = jtl_pkg::M_INNER;
          if (!e && b == jtl_pkg::CH_MINUS) begin
            finish = 1'b1;
          end else begin
            phase_d = jtl_pkg::P_FEED;
          end
        end
        jtl_pkg::P_ESC2: begin
          cmd_o.op   = jtl_pkg::DP_ADD;
          cmd_o.kind = jtl_pkg::TK_STRING;
          cmd_o.ch   = b;
          finish     = 1'b1;
        end
        jtl_pkg::P_RST: begin
          cmd_o.op     = jtl_pkg::DP_RESET;
          mode_d       = jtl_pkg::M_TEXT;
          stmt_d       = 1'b0;
          qd_d         = 1'b0;
          dot_d        = 1'b0;
          item_eof_d   = 1'b0;
          phase_d      = jtl_pkg::P_IDLE;
        end
        jtl_pkg::P_IDLE: begin
        end
        default: begin
          phase_d = jtl_pkg::P_IDLE;
        end
      endcase
    end

    if (failed) begin
      mode_d = jtl_pkg::M_ERR;
      finish = 1'b1;
    end
    if (finish) begin
      if (sec_valid_q && !failed) begin
        sym_d       = sec_q;
        sym_eof_d   = sec_eof_q;
        sec_valid_d = 1'b0;
        phase_d     = jtl_pkg::P_FEED;
      end else begin
        sec_valid_d = 1'b0;
        phase_d     = item_eof_q ? jtl_pkg::P_RST : jtl_pkg::P_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= jtl_pkg::P_IDLE;
      mode_q       <= jtl_pkg::M_TEXT;
      cont_q       <= jtl_pkg::C_TADD;
      sym_q        <= 8'h00;
      sym_eof_q    <= 1'b0;
      item_eof_q   <= 1'b0;
      sec_q        <= 8'h00;
      sec_eof_q    <= 1'b0;
      sec_valid_q  <= 1'b0;
      held_q       <= 8'h00;
      tc_q         <= 8'h00;
      stmt_q       <= 1'b0;
      qd_q         <= 1'b0;
      dot_q        <= 1'b0;
      trim_q       <= 1'b0;
      after_feed_q <= 1'b0;
      close_open_q <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      mode_q       <= mode_d;
      cont_q       <= cont_d;
      sym_q        <= sym_d;
      sym_eof_q    <= sym_eof_d;
      item_eof_q   <= item_eof_d;
      sec_q        <= sec_d;
      sec_eof_q    <= sec_eof_d;
      sec_valid_q  <= sec_valid_d;
      held_q       <= held_d;
      tc_q         <= tc_d;
      stmt_q       <= stmt_d;
      qd_q         <= qd_d;
      dot_q        <= dot_d;
      trim_q       <= trim_d;
      after_feed_q <= after_feed_d;
      close_open_q <= close_open_d;
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the template lexer: directed and random templates, scoreboard, stream drivers.
module testbench;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] ch;
    logic       has;
    logic       first;
    logic       last;
    logic [2:0] err;
  } token_res_t;

  class lexer_scoreboard;
    token_res_t          tokens_due[$];
    int                  mismatches;
    int                  tokens_seen;
    int                  step_n;
    jtl_pkg::scan_mode_e mode;
    logic [7:0]          held0;
    logic [7:0]          pend[jtl_pkg::SPACE_DEPTH];
    int                  pend_n;
    bit                  tag_stmt, dq, has_dot, text_open, started, dly_v, cut;
    logic [7:0]          dly_ch;

    function new();
      mismatches = 0;
      tokens_seen = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode = jtl_pkg::M_TEXT;
      held0 = 8'h00;
      pend_n = 0;
      tag_stmt = 0; dq = 0; has_dot = 0; text_open = 0; started = 0;
      dly_v = 0; cut = 0; dly_ch = 8'h00;
    endfunction

    function bit ws(int b);
      return b == jtl_pkg::CH_SPACE || b == jtl_pkg::CH_TAB ||
             b == jtl_pkg::CH_LF || b == jtl_pkg::CH_CR;
    endfunction
    function bit digit(int b);
      return b >= "0" && b <= "9";
    endfunction
    function bit alpha(int b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function void put(logic [4:0] k, logic [7:0] c, bit h, bit f, bit l, logic [2:0] e);
      token_res_t r;
      if (step_n >= 40) return;
      r.kind = k; r.ch = c; r.has = h; r.first = f; r.last = l; r.err = e;
      tokens_due.insert(tokens_due.size(), r);
      step_n++;
    endfunction

    function void emit(logic [4:0] k, logic [7:0] c, bit h, bit f, bit l);
      if (mode == jtl_pkg::M_ERR) return;
      put(k, c, h, f, l, jtl_pkg::ERR_NONE);
    endfunction

    function void fail(logic [2:0] e);
      if (mode == jtl_pkg::M_ERR) return;
      put(jtl_pkg::TK_TEXT, 8'h00, 0, 1, 1, e);
      mode = jtl_pkg::M_ERR;
    endfunction

    function void fixed_tok(logic [4:0] k);
      emit(k, 8'h00, 0, 1, 1);
    endfunction

    function void add_char(logic [4:0] k, logic [7:0] c);
      if (dly_v) begin
        emit(k, dly_ch, 1, !started, 0);
        started = 1;
      end
      dly_ch = c;
      dly_v = 1;
    endfunction

    function void close_tok(logic [4:0] k, bit allow_empty);
      if (dly_v) emit(k, dly_ch, 1, !started, 1);
      else if (allow_empty && !started) emit(k, 8'h00, 0, 1, 1);
      dly_v = 0;
      started = 0;
    endfunction

    function void text_commit();
      for (int i = 0; i < pend_n; i++) add_char(jtl_pkg::TK_TEXT, pend[i]);
      pend_n = 0;
    endfunction

    function void text_char(logic [7:0] c);
      if (cut) begin
        cut = 0;
        text_commit();
      end
      text_open = 1;
      if (ws(c)) begin
        if (pend_n >= jtl_pkg::SPACE_DEPTH) begin
          fail(jtl_pkg::ERR_OVERFLOW);
          return;
        end
        pend[pend_n] = c;
        pend_n++;
      end else begin
        text_commit();
        add_char(jtl_pkg::TK_TEXT, c);
      end
    endfunction

    function void text_close(bit trim);
      if (trim) pend_n = 0;
      else text_commit();
      close_tok(jtl_pkg::TK_TEXT, 0);
      text_open = 0;
      cut = 0;
    endfunction

    function void close_tag(bit rtrim);
      fixed_tok(tag_stmt ? jtl_pkg::TK_STMT_CLOSE : jtl_pkg::TK_EXPR_CLOSE);
      mode = rtrim ? jtl_pkg::M_RT_SP : jtl_pkg::M_TEXT;
    endfunction

    function void inner_byte(int b);
      int e0;
      e0 = tag_stmt ? jtl_pkg::CH_PCT : jtl_pkg::CH_RBRACE;
      if (b < 0) begin
        fail(jtl_pkg::ERR_OPEN_TAG);
        return;
      end
      if (ws(b)) return;
      if (b == jtl_pkg::CH_MINUS) begin mode = jtl_pkg::M_DASH1; return; end
      if (b == e0) begin mode = jtl_pkg::M_END1; return; end
      if (b == jtl_pkg::CH_DQUOTE || b == jtl_pkg::CH_SQUOTE) begin
        dq = (b == jtl_pkg::CH_DQUOTE);
        dly_v = 0; started = 0;
        mode = jtl_pkg::M_STR;
        return;
      end
      if (digit(b)) begin
        has_dot = 0; mode = jtl_pkg::M_NUM; add_char(jtl_pkg::TK_INT, b[7:0]);
        return;
      end
      if (alpha(b) || b == jtl_pkg::CH_UNDER) begin
        mode = jtl_pkg::M_ID; add_char(jtl_pkg::TK_IDENT, b[7:0]);
        return;
      end
      case (b)
        ".": fixed_tok(jtl_pkg::TK_DOT);
        ",": fixed_tok(jtl_pkg::TK_COMMA);
        "|": fixed_tok(jtl_pkg::TK_PIPE);
        "(": fixed_tok(jtl_pkg::TK_LPAREN);
        ")": fixed_tok(jtl_pkg::TK_RPAREN);
        "[": fixed_tok(jtl_pkg::TK_LBRACK);
        "]": fixed_tok(jtl_pkg::TK_RBRACK);
        "+": fixed_tok(jtl_pkg::TK_PLUS);
        "*": fixed_tok(jtl_pkg::TK_STAR);
        "/": fixed_tok(jtl_pkg::TK_SLASH);
        "%": fixed_tok(jtl_pkg::TK_MOD);
        "~": fixed_tok(jtl_pkg::TK_TILDE);
        ":": fixed_tok(jtl_pkg::TK_COLON);
        "=", "!", "<", ">": begin
          held0 = b[7:0];
          mode = jtl_pkg::M_OP;
        end
        default: fail(jtl_pkg::ERR_BAD_CHAR);
      endcase
    endfunction

    function void op_byte(int b);
      if (b == jtl_pkg::CH_EQ) begin
        mode = jtl_pkg::M_INNER;
        fixed_tok(held0 == jtl_pkg::CH_EQ ? jtl_pkg::TK_EQ :
                  held0 == jtl_pkg::CH_BANG ? jtl_pkg::TK_NE :
                  held0 == jtl_pkg::CH_LT ? jtl_pkg::TK_LE : jtl_pkg::TK_GE);
      end else if (held0 == jtl_pkg::CH_BANG) begin
        fail(jtl_pkg::ERR_BAD_CHAR);
      end else begin
        mode = jtl_pkg::M_INNER;
        fixed_tok(held0 == jtl_pkg::CH_EQ ? jtl_pkg::TK_ASSIGN :
                  held0 == jtl_pkg::CH_LT ? jtl_pkg::TK_LT : jtl_pkg::TK_GT);
        feed(b);
      end
    endfunction

    function void esc_byte(int b);
      if (b < 0) begin
        fail(jtl_pkg::ERR_OPEN_STR);
        return;
      end
      mode = jtl_pkg::M_STR;
      case (b)
        jtl_pkg::CH_N:      add_char(jtl_pkg::TK_STRING, jtl_pkg::CH_LF);
        jtl_pkg::CH_T:      add_char(jtl_pkg::TK_STRING, jtl_pkg::CH_TAB);
        jtl_pkg::CH_R:      add_char(jtl_pkg::TK_STRING, jtl_pkg::CH_CR);
        jtl_pkg::CH_BSLASH: add_char(jtl_pkg::TK_STRING, jtl_pkg::CH_BSLASH);
        jtl_pkg::CH_SQUOTE: add_char(jtl_pkg::TK_STRING, jtl_pkg::CH_SQUOTE);
        jtl_pkg::CH_DQUOTE: add_char(jtl_pkg::TK_STRING, jtl_pkg::CH_DQUOTE);
        default: begin
          add_char(jtl_pkg::TK_STRING, jtl_pkg::CH_BSLASH);
          add_char(jtl_pkg::TK_STRING, b[7:0]);
        end
      endcase
    endfunction

    function void feed(int b);
      int e0;
      e0 = tag_stmt ? jtl_pkg::CH_PCT : jtl_pkg::CH_RBRACE;
      case (mode)
        jtl_pkg::M_TEXT: begin
          if (b < 0) begin
            text_close(0);
            fixed_tok(jtl_pkg::TK_EOF);
          end else if (b == jtl_pkg::CH_LBRACE) mode = jtl_pkg::M_TEXT_LB;
          else text_char(b[7:0]);
        end
        jtl_pkg::M_TEXT_LB: begin
          if (b == jtl_pkg::CH_LBRACE || b == jtl_pkg::CH_PCT) begin
            tag_stmt = (b == jtl_pkg::CH_PCT);
            mode = jtl_pkg::M_OPEN;
          end else if (b == jtl_pkg::CH_HASH) mode = jtl_pkg::M_CMT;
          else begin
            mode = jtl_pkg::M_TEXT;
            text_char(jtl_pkg::CH_LBRACE);
            feed(b);
          end
        end
        jtl_pkg::M_OPEN: begin
          text_close(b == jtl_pkg::CH_MINUS);
          fixed_tok(tag_stmt ? jtl_pkg::TK_STMT_OPEN : jtl_pkg::TK_EXPR_OPEN);
          mode = jtl_pkg::M_INNER;
          if (b != jtl_pkg::CH_MINUS) feed(b);
        end
        jtl_pkg::M_CMT: begin
          if (b < 0) fail(jtl_pkg::ERR_OPEN_CMT);
          else if (b == jtl_pkg::CH_HASH) mode = jtl_pkg::M_CMT_HASH;
        end
        jtl_pkg::M_CMT_HASH: begin
          if (b < 0) fail(jtl_pkg::ERR_OPEN_CMT);
          else if (b == jtl_pkg::CH_RBRACE) begin
            mode = jtl_pkg::M_TEXT;
            cut = 1;
          end else if (b != jtl_pkg::CH_HASH) mode = jtl_pkg::M_CMT;
        end
        jtl_pkg::M_INNER: inner_byte(b);
        jtl_pkg::M_DASH1: begin
          if (b == e0) mode = jtl_pkg::M_DASH2;
          else begin
            mode = jtl_pkg::M_INNER;
            fixed_tok(jtl_pkg::TK_MINUS);
            feed(b);
          end
        end
        jtl_pkg::M_DASH2: begin
          if (b == jtl_pkg::CH_RBRACE) close_tag(1);
          else begin
            mode = jtl_pkg::M_INNER;
            fixed_tok(jtl_pkg::TK_MINUS);
            feed(e0);
            feed(b);
          end
        end
        jtl_pkg::M_END1: begin
          if (b == jtl_pkg::CH_RBRACE) close_tag(0);
          else if (!tag_stmt) fail(jtl_pkg::ERR_BAD_CHAR);
          else begin
            mode = jtl_pkg::M_INNER;
            fixed_tok(jtl_pkg::TK_MOD);
            feed(b);
          end
        end
        jtl_pkg::M_OP: op_byte(b);
        jtl_pkg::M_STR: begin
          if (b < 0) fail(jtl_pkg::ERR_OPEN_STR);
          else if (b == (dq ? jtl_pkg::CH_DQUOTE : jtl_pkg::CH_SQUOTE)) begin
            close_tok(jtl_pkg::TK_STRING, 1);
            mode = jtl_pkg::M_INNER;
          end else if (b == jtl_pkg::CH_BSLASH) mode = jtl_pkg::M_ESC;
          else add_char(jtl_pkg::TK_STRING, b[7:0]);
        end
        jtl_pkg::M_ESC: esc_byte(b);
        jtl_pkg::M_NUM: begin
          if (digit(b)) add_char(has_dot ? jtl_pkg::TK_FLOAT : jtl_pkg::TK_INT, b[7:0]);
          else if (b == jtl_pkg::CH_DOT && !has_dot) begin
            has_dot = 1;
            add_char(jtl_pkg::TK_FLOAT, jtl_pkg::CH_DOT);
          end else begin
            close_tok(has_dot ? jtl_pkg::TK_FLOAT : jtl_pkg::TK_INT, 0);
            mode = jtl_pkg::M_INNER;
            feed(b);
          end
        end
        jtl_pkg::M_ID: begin
          if (alpha(b) || digit(b) || b == jtl_pkg::CH_UNDER)
            add_char(jtl_pkg::TK_IDENT, b[7:0]);
          else begin
            close_tok(jtl_pkg::TK_IDENT, 0);
            mode = jtl_pkg::M_INNER;
            feed(b);
          end
        end
        jtl_pkg::M_RT_SP: begin
          if (b == jtl_pkg::CH_SPACE || b == jtl_pkg::CH_TAB) begin
          end else if (b == jtl_pkg::CH_LF) mode = jtl_pkg::M_TEXT;
          else if (b == jtl_pkg::CH_CR) mode = jtl_pkg::M_RT_CR;
          else begin
            mode = jtl_pkg::M_TEXT;
            feed(b);
          end
        end
        jtl_pkg::M_RT_CR: begin
          mode = jtl_pkg::M_TEXT;
          if (b != jtl_pkg::CH_LF) feed(b);
        end
        default: begin
        end
      endcase
    endfunction

    function void note_request(logic kind, logic [7:0] b);
      step_n = 0;
      if (kind) begin
        feed(-1);
        clear_state();
      end else begin
        feed(b);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_token(logic [23:0] data, logic last);
      token_res_t got, want;
      got.kind = data[4:0]; got.ch = data[12:5]; got.has = data[13];
      got.first = data[14]; got.err = data[17:15]; got.last = last;
      tokens_seen++;
      if (tokens_due.size() == 0) begin
        report($sformatf("unexpected token %h", got));
        return;
      end
      want = tokens_due.pop_front();
      if (got !== want || data[23:18] !== 6'd0)
        report($sformatf({"kind %0d/%0d char %h/%h has %b/%b first %b/%b",
                          " last %b/%b err %0d/%0d"},
                         got.kind, want.kind, got.ch, want.ch, got.has, want.has,
                         got.first, want.first, got.last, want.last, got.err, want.err));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic        m_last;

  lexer_scoreboard sb = new();
  logic [7:0] tmpl_q[$];
  int  send_idle = 0;
  int  recv_stall = 0;
  int  hold_req = 0;
  int  items_sent = 0;

  jinja_template_lexer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) sb.check_token(m_data, m_last);
  end

  task send_request(logic kind, logic [7:0] b);
    if ($urandom_range(99) < send_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= kind;
    s_data <= b;
    do @(posedge clk_i); while (!s_ready);
    sb.note_request(kind, b);
    items_sent++;
  endtask

  task add_byte(logic [7:0] c);
    tmpl_q.insert(tmpl_q.size(), c);
  endtask

  task push_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task send_template(bit with_end);
    foreach (tmpl_q[i]) send_request(1'b0, tmpl_q[i]);
    tmpl_q.delete();
    if (with_end) send_request(1'b1, 8'($urandom_range(255)));
  endtask

  task put_text();
    int n;
    n = $urandom_range(1, 6);
    if ($urandom_range(19) == 0) n = $urandom_range(28, 34);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1, 2: add_byte(pick("abXyz_09"));
        3, 4, 5, 6: add_byte(pick(" \t\n\r"));
        7: push_str("{x");
        8: add_byte(pick("}-#%"));
        default: add_byte(8'($urandom_range(128, 255)));
      endcase
      if (n > 20) tmpl_q[tmpl_q.size() - 1] = pick(" \t\n\r");
    end
  endtask

  task put_comment();
    push_str("{#");
    repeat ($urandom_range(0, 4)) add_byte(pick("a #}{%-"));
    push_str("#}");
  endtask

  task put_tag();
    bit stmt, ltrim, rtrim;
    stmt = 1'($urandom_range(1));
    ltrim = 1'($urandom_range(1));
    rtrim = 1'($urandom_range(1));
    push_str(stmt ? "{%" : "{{");
    if (ltrim) add_byte(jtl_pkg::CH_MINUS);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(1)) add_byte(pick(" \t\n"));
      case ($urandom_range(4))
        0: begin
          add_byte(pick("abzAZ_"));
          repeat ($urandom_range(0, 3)) add_byte(pick("az09_Q"));
        end
        1: begin
          repeat ($urandom_range(1, 3)) add_byte(pick("0123456789"));
          if ($urandom_range(1)) add_byte(jtl_pkg::CH_DOT);
          repeat ($urandom_range(0, 2)) add_byte(pick("0579"));
          if ($urandom_range(3) == 0) add_byte(jtl_pkg::CH_DOT);
        end
        2: begin
          logic [7:0] q;
          q = $urandom_range(1) ? jtl_pkg::CH_DQUOTE : jtl_pkg::CH_SQUOTE;
          add_byte(q);
          repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(2) == 0) begin
              add_byte(jtl_pkg::CH_BSLASH);
              add_byte(pick("ntr\\'\"q{"));
            end else add_byte(pick("a %}'\"-"));
            if (tmpl_q[tmpl_q.size() - 1] == q &&
                tmpl_q[tmpl_q.size() - 2] != jtl_pkg::CH_BSLASH)
              tmpl_q[tmpl_q.size() - 1] = "k";
          end
          add_byte(q);
        end
        3: begin
          case ($urandom_range(4))
            0: push_str("==");
            1: push_str("!=");
            2: push_str("<=");
            3: push_str(">=");
            default: push_str("- ");
          endcase
        end
        default: add_byte(pick(stmt ? ".,|()[]+*/~:=<>" : ".,|()[]+*/~:%=<>"));
      endcase
    end
    if (rtrim) add_byte(jtl_pkg::CH_MINUS);
    push_str(stmt ? "%}" : "}}");
    if (rtrim) begin
      repeat ($urandom_range(0, 2)) add_byte(pick(" \t"));
      case ($urandom_range(3))
        0: push_str("\n");
        1: push_str("\r\n");
        2: push_str("\r");
        default: ;
      endcase
    end
  endtask

  task wait_drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.tokens_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int phase, cut_at;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_str("a {{-x.y|f(1,2.5)~'\\n\\q\"' != b}} {#c#}\t{%-k%2-%}  \r\nz");
    send_template(1);
    push_str("{{ 9.1.2 <=>= !}");
    send_template(1);
    push_str("{%\"\\");
    send_template(1);
    send_request(1'b0, 8'hFF);
    send_template(1);
    wait_drain();

    while (items_sent < 280) begin
      phase = (items_sent - 80) * 4 / 200;
      if (phase < 0) phase = 0;
      if (phase > 3) phase = 3;
      send_idle = (phase == 1) ? 66 : (phase == 3) ? 7 : 0;
      recv_stall = (phase == 2) ? 66 : (phase == 3) ? 7 : 0;
      if (phase == 2 && hold_req == 0 && recv_stall == 66 && $urandom_range(9) == 0)
        hold_req = 300;
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(5))
          0, 1: put_text();
          2: put_comment();
          default: put_tag();
        endcase
      end
      if ($urandom_range(9) == 0)
        tmpl_q.insert($urandom_range(tmpl_q.size() - 1), 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        cut_at = $urandom_range(tmpl_q.size() - 1);
        while (tmpl_q.size() > cut_at) void'(tmpl_q.pop_back());
      end
      send_template(1);
      if (phase == 1 && $urandom_range(7) == 0) wait_drain();
    end

    wait_drain();
    repeat (100) @(posedge clk_i);
    if (sb.tokens_due.size() != 0)
      sb.report($sformatf("%0d tokens never arrived", sb.tokens_due.size()));
    $display("Covered %0d template requests and %0d token results,", items_sent,
             sb.tokens_seen);
    $display("with idle, stall and hold-off phases.");
    if (sb.mismatches == 0) begin
      $display("jinja_template_lexer_top test passed");
    end else begin
      $display("jinja_template_lexer_top test failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Timeout with %0d tokens outstanding", sb.tokens_due.size());
    $display("jinja_template_lexer_top test failed");
    $finish;
  end

endmodule
